>>> rtl/core/srag_pkg.sv
// ----------------------------------------------------------------------------
// srag_pkg
// Shared types and constants of the strip row address generator.
// ----------------------------------------------------------------------------
package srag_pkg;

	localparam int unsigned IDX_IN_W  = 10;
	localparam int unsigned DIM_W     = 16;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned OFS_W     = 32;
	localparam int unsigned ADDR_W    = 34;
	localparam int unsigned LEN_W     = 17;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_ROWS_PER_STRIP = 3'd2,
		REG_STRIP_COUNT    = 3'd3,
		REG_FILE_SIZE      = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2,
		ST_BOUNDS  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_L_MUL1,
		S_L_ROWS,
		S_L_MUL2,
		S_L_CHK,
		S_R_CHK,
		S_R_DIV,
		S_R_RNG,
		S_R_ADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic ld_mul1;
		logic ld_rows;
		logic ld_mul2;
		logic ld_fin;
		logic rd_inval;
		logic div_start;
		logic div_step;
		logic rd_range_err;
		logic rd_go;
		logic rd_fin;
		logic out_load;
	} srag_cmd_t;

	typedef struct packed {
		logic rd_invalid;
		logic div_done;
		logic rd_in_range;
	} srag_stat_t;

endpackage

>>> rtl/core/strip_row_address_generator_top.sv
// ----------------------------------------------------------------------------
// strip_row_address_generator_top
// Strip offset table with row segment address generation for strip images.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group; tuser selects a load of a strip entry
// (0) or a row read (1). Every request gives one result on m_axis: status,
// byte address and byte length. Configuration goes through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while no request is
// in flight, as the block itself does not enforce this. A row read passes
// through the span check, the 16 steps of the restoring divider for
// row / rows_per_strip, the hand-off out of the divider, the range check
// with table read and multiply, the add and the output register. A row read
// that fails its span check goes straight to the output register.
// One request is in flight at a time; s_axis_tready rises again as soon as
// the result moves into the output register, so the next request may enter
// while that result still waits. When m_axis_tready stays low, the finished
// result is held and the sequencer waits with the next one.
// Reset restores the register defaults and empties the output; the offset
// table holds no content until loaded.
// ----------------------------------------------------------------------------
module strip_row_address_generator_top import srag_pkg::*; #(
	parameter int unsigned MAX_STRIPS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [9:0] strip_index, [41:10] strip_offset, [73:42] strip_byte_count,
	// [89:74] row, [105:90] col_start, [121:106] col_end
	input  logic [127:0]         s_axis_tdata,
	// [0] command
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [1:0] status, [35:2] byte_address, [52:36] byte_length
	output logic [55:0]          m_axis_tdata
);

	srag_cmd_t         cmd;
	srag_stat_t        stat;
	status_t           status;
	logic [ADDR_W-1:0] byte_address;
	logic [LEN_W-1:0]  byte_length;

	srag_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.out_ready  (m_axis_tready),
		.stat       (stat),
		.cmd        (cmd),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid)
	);

	srag_dp #(
		.MAX_STRIPS (MAX_STRIPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.strip_index      (s_axis_tdata[9:0]),
		.strip_offset     (s_axis_tdata[41:10]),
		.strip_byte_count (s_axis_tdata[73:42]),
		.row              (s_axis_tdata[89:74]),
		.col_start        (s_axis_tdata[105:90]),
		.col_end          (s_axis_tdata[121:106]),
		.cmd              (cmd),
		.stat             (stat),
		.status           (status),
		.byte_address     (byte_address),
		.byte_length      (byte_length)
	);

	assign m_axis_tdata = {3'b0, byte_length, byte_address, status};

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (status != ST_OK) |-> (byte_address == '0) && (byte_length == '0))
		else $error("error result carries an address or length");

	a_load_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_go |-> $past(stat.div_done))
		else $error("table read before the divider finished");
`endif

endmodule

>>> rtl/core/srag_ctrl.sv
// ----------------------------------------------------------------------------
// srag_ctrl
// Sequencer for load and row read requests; owns the output valid flag.
// ----------------------------------------------------------------------------
module srag_ctrl import srag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_command,
	input  logic       out_ready,
	input  srag_stat_t stat,
	output srag_cmd_t  cmd,
	output logic       in_ready,
	output logic       out_valid
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = in_command ? S_R_CHK : S_L_MUL1;
				end
			end
			S_L_MUL1: begin
				cmd.ld_mul1 = 1'b1;
				state_d     = S_L_ROWS;
			end
			S_L_ROWS: begin
				cmd.ld_rows = 1'b1;
				state_d     = S_L_MUL2;
			end
			S_L_MUL2: begin
				cmd.ld_mul2 = 1'b1;
				state_d     = S_L_CHK;
			end
			S_L_CHK: begin
				cmd.ld_fin = 1'b1;
				state_d    = S_DONE;
			end
			S_R_CHK: begin
				if (stat.rd_invalid) begin
					cmd.rd_inval = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_R_DIV;
				end
			end
			S_R_DIV: begin
				if (stat.div_done) begin
					state_d = S_R_RNG;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_R_RNG: begin
				if (stat.rd_in_range) begin
					cmd.rd_go = 1'b1;
					state_d   = S_R_ADD;
				end else begin
					cmd.rd_range_err = 1'b1;
					state_d          = S_DONE;
				end
			end
			S_R_ADD: begin
				cmd.rd_fin = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/srag_dp.sv
// ----------------------------------------------------------------------------
// srag_dp
// Configuration registers, strip offset table, row divider and address math.
// ----------------------------------------------------------------------------
module srag_dp import srag_pkg::*; #(
	parameter int unsigned MAX_STRIPS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [IDX_IN_W-1:0]  strip_index,
	input  logic [OFS_W-1:0]     strip_offset,
	input  logic [OFS_W-1:0]     strip_byte_count,
	input  logic [DIM_W-1:0]     row,
	input  logic [DIM_W-1:0]     col_start,
	input  logic [DIM_W-1:0]     col_end,
	input  srag_cmd_t            cmd,
	output srag_stat_t           stat,
	output status_t              status,
	output logic [ADDR_W-1:0]    byte_address,
	output logic [LEN_W-1:0]     byte_length
);

	localparam int unsigned IDX_W       = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
	localparam logic [16:0] STRIP_LIMIT = 17'(MAX_STRIPS);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] rps_q;
	logic [CNT_W-1:0] scount_q;
	logic [OFS_W-1:0] fsize_q;

	logic [IDX_IN_W-1:0] idx_q;
	logic [OFS_W-1:0]    ofs_q;
	logic [OFS_W-1:0]    bcnt_q;
	logic [DIM_W-1:0]    row_q;
	logic [DIM_W-1:0]    cs_q;
	logic [DIM_W-1:0]    ce_q;

	logic [IDX_IN_W+DIM_W-1:0] first_row_s1;
	logic [OFS_W:0]            end_s1;
	logic [DIM_W-1:0]          rows_q;
	logic [2*DIM_W-1:0]        req_s2;

	logic [DIM_W-1:0]  quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIM_W+1:0]  trial;

	logic [OFS_W-1:0]   mem [MAX_STRIPS];
	logic [OFS_W-1:0]   mem_rd_q;
	logic [2*DIM_W-1:0] prod_s1;

	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [LEN_W-1:0]  res_len_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [LEN_W-1:0]  out_len_q;

	logic [15:0]        idx_ext;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic               ld_range_ok;
	logic               ld_bounds_bad;
	logic [DIM_W-1:0]   rows_left;
	logic [2*DIM_W:0]   seg_sum;
	logic [ADDR_W:0]    addr_sum;
	logic [DIM_W-1:0]   span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(2);
			height_q <= DIM_W'(2);
			rps_q    <= DIM_W'(1);
			scount_q <= CNT_W'(1);
			fsize_q  <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:    width_q  <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_wdata[DIM_W-1:0];
				REG_ROWS_PER_STRIP: rps_q    <= cfg_wdata[DIM_W-1:0];
				REG_STRIP_COUNT:    scount_q <= cfg_wdata[CNT_W-1:0];
				REG_FILE_SIZE:      fsize_q  <= cfg_wdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= strip_index;
			ofs_q  <= strip_offset;
			bcnt_q <= strip_byte_count;
			row_q  <= row;
			cs_q   <= col_start;
			ce_q   <= col_end;
		end
	end

	assign idx_ext     = {6'b0, idx_q};
	assign wr_addr     = idx_ext[IDX_W-1:0];
	assign rd_addr     = quo_q[IDX_W-1:0];
	assign ld_range_ok = ({1'b0, idx_q} < scount_q) && ({7'b0, idx_q} < STRIP_LIMIT);
	assign rows_left   = height_q - first_row_s1[DIM_W-1:0];
	assign ld_bounds_bad = ({1'b0, bcnt_q} < {req_s2, 1'b0}) || (end_s1 > {1'b0, fsize_q});

	// load path: strip rows, required bytes, end of strip
	always_ff @(posedge clk) begin
		if (cmd.ld_mul1) begin
			first_row_s1 <= idx_q * rps_q;
			end_s1       <= {1'b0, ofs_q} + {1'b0, bcnt_q};
		end
		if (cmd.ld_rows) begin
			if (first_row_s1 >= {{IDX_IN_W{1'b0}}, height_q}) begin
				rows_q <= '0;
			end else if (rows_left > rps_q) begin
				rows_q <= rps_q;
			end else begin
				rows_q <= rows_left;
			end
		end
		if (cmd.ld_mul2) begin
			req_s2 <= rows_q * width_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_fin && ld_range_ok && !ld_bounds_bad) begin
			mem[wr_addr] <= ofs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_go) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// restoring divider, one quotient bit per step
	assign trial = {1'b0, rem_q, quo_q[DIM_W-1]} - {2'b0, rps_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= DCNT_W'(DIV_STEPS);
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= row_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial[DIM_W+1]) begin
				rem_q <= {rem_q[DIM_W-2:0], quo_q[DIM_W-1]};
				quo_q <= {quo_q[DIM_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DIM_W-1:0];
				quo_q <= {quo_q[DIM_W-2:0], 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_go) begin
			prod_s1 <= rem_q * width_q;
		end
	end

	assign seg_sum  = {1'b0, prod_s1} + {{(DIM_W+1){1'b0}}, cs_q};
	assign addr_sum = {3'b0, mem_rd_q} + {1'b0, seg_sum, 1'b0};
	assign span     = ce_q - cs_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_fin) begin
			res_addr_q <= '0;
			res_len_q  <= '0;
			if (!ld_range_ok) begin
				res_status_q <= ST_RANGE;
			end else if (ld_bounds_bad) begin
				res_status_q <= ST_BOUNDS;
			end else begin
				res_status_q <= ST_OK;
			end
		end else if (cmd.rd_inval) begin
			res_status_q <= ST_INVALID;
			res_addr_q   <= '0;
			res_len_q    <= '0;
		end else if (cmd.rd_range_err) begin
			res_status_q <= ST_RANGE;
			res_addr_q   <= '0;
			res_len_q    <= '0;
		end else if (cmd.rd_fin) begin
			res_status_q <= ST_OK;
			res_addr_q   <= addr_sum[ADDR_W-1:0];
			res_len_q    <= {span, 1'b0};
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_len_q    <= res_len_q;
		end
	end

	assign stat.rd_invalid  = (cs_q >= ce_q) || (ce_q > width_q) || (row_q >= height_q) ||
		(rps_q == '0);
	assign stat.div_done    = (dcnt_q == '0);
	assign stat.rd_in_range = ({5'b0, quo_q} < {{(DIM_W-CNT_W+5){1'b0}}, scount_q}) &&
		({1'b0, quo_q} < STRIP_LIMIT);

	assign status       = out_status_q;
	assign byte_address = out_addr_q;
	assign byte_length  = out_len_q;

endmodule
